// File: hw/rtl/mxae_pkg.sv
// Shared types, constants and helper functions for the 4x4 matrix arithmetic engine.
// Used by mxae_lane, mxae_merge and matrix4x4_arith_engine_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mxae_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 32;
    localparam int DIM        = 4;
    localparam int ROW_W      = $clog2(DIM);
    localparam int CNT_W      = $clog2(DIM + 1);
    localparam int XW         = (ELEM_WIDTH > FIELD_W) ? ELEM_WIDTH : FIELD_W;
    localparam int PROD_W     = 2 * ELEM_WIDTH;
    localparam int ACC_W      = PROD_W + 2;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_SUB   = 2'd1,
        CMD_SCALE = 2'd2,
        CMD_MUL   = 2'd3
    } cmd_t;

    typedef enum logic {
        SEQ_LOAD  = 1'b0,
        SEQ_ISSUE = 1'b1
    } seq_state_t;

    typedef struct packed {
        cmd_t                      command;
        logic [1:0]                row_index;
        logic signed [FIELD_W-1:0] left_e0;
        logic signed [FIELD_W-1:0] left_e1;
        logic signed [FIELD_W-1:0] left_e2;
        logic signed [FIELD_W-1:0] left_e3;
        logic signed [FIELD_W-1:0] right_e0;
        logic signed [FIELD_W-1:0] right_e1;
        logic signed [FIELD_W-1:0] right_e2;
        logic signed [FIELD_W-1:0] right_e3;
        logic signed [FIELD_W-1:0] scale_factor;
        logic                      final_row;
    } item_t;

    typedef struct packed {
        logic [1:0]                out_row;
        logic signed [FIELD_W-1:0] out_e0;
        logic signed [FIELD_W-1:0] out_e1;
        logic signed [FIELD_W-1:0] out_e2;
        logic signed [FIELD_W-1:0] out_e3;
        logic                      out_last;
        logic                      out_saturated;
    } result_t;

    // Operands for one lane: for a product a holds a left row and b a right column,
    // otherwise only element 0 of each is used and the rest are zero.
    typedef struct packed {
        logic                valid;
        cmd_t                op;
        elem_t [DIM-1:0]     a;
        elem_t [DIM-1:0]     b;
    } lane_op_t;

    typedef struct packed {
        logic  valid;
        elem_t value;
        logic  clip;
    } lane_res_t;

    // An element is the low ELEM_WIDTH bits of its field.
    function automatic elem_t to_elem(input logic [FIELD_W-1:0] f);
        logic [XW-1:0] t;
        t = XW'(f);
        return t[ELEM_WIDTH-1:0];
    endfunction

    // A result field carries the element bits, zero above ELEM_WIDTH.
    function automatic logic [FIELD_W-1:0] to_field(input elem_t e);
        logic [XW-1:0] t;
        t = XW'($unsigned(e));
        return t[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mxae_lane.sv
// One arithmetic lane: computes one column element of a result row in four stages.
// Depends on mxae_pkg for operand and result types and the fixed-point constants.
`timescale 1ns / 1ps
`default_nettype none

module mxae_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mxae_pkg::lane_op_t  op_in,
    output mxae_pkg::lane_res_t      res
);
    import mxae_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    elem_t opa [DIM];
    elem_t opb [DIM];

    logic                      s1_valid_reg, s1_valid_next;
    cmd_t                      s1_op_reg, s1_op_next;
    logic signed [PROD_W-1:0]  s1_prod_reg [DIM];
    logic signed [PROD_W-1:0]  s1_prod_next [DIM];
    logic signed [ELEM_WIDTH:0] s1_sum_reg, s1_sum_next;

    logic                      s2_valid_reg, s2_valid_next;
    logic                      s2_round_reg, s2_round_next;
    logic signed [ACC_W-1:0]   s2_lo_reg, s2_lo_next;
    logic signed [ACC_W-1:0]   s2_hi_reg, s2_hi_next;

    logic                      s3_valid_reg, s3_valid_next;
    logic                      s3_round_reg, s3_round_next;
    logic signed [ACC_W-1:0]   s3_acc_reg, s3_acc_next;

    logic                      s4_valid_reg, s4_valid_next;
    elem_t                     s4_value_reg, s4_value_next;
    logic                      s4_clip_reg, s4_clip_next;

    logic                      addsub;
    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-ELEM_WIDTH:0] upper;
    logic                      fits;

    // Stage 1: four products, plus the exact sum or difference of element 0.
    always_comb
    begin
        s1_valid_next = op_in.valid;
        s1_op_next    = op_in.op;
        for (int k = 0; k < DIM; k++)
        begin
            opa[k]          = op_in.a[k];
            opb[k]          = op_in.b[k];
            s1_prod_next[k] = opa[k] * opb[k];
        end
        if (op_in.op == CMD_SUB)
        begin
            s1_sum_next = (ELEM_WIDTH+1)'(opa[0]) - (ELEM_WIDTH+1)'(opb[0]);
        end
        else
        begin
            s1_sum_next = (ELEM_WIDTH+1)'(opa[0]) + (ELEM_WIDTH+1)'(opb[0]);
        end
    end

    // Stage 2: pairwise product sums, or the sum or difference passed on; unused products of a scale are zero.
    always_comb
    begin
        addsub        = (s1_op_reg == CMD_ADD) || (s1_op_reg == CMD_SUB);
        s2_valid_next = s1_valid_reg;
        s2_round_next = !addsub;
        if (addsub)
        begin
            s2_lo_next = ACC_W'(s1_sum_reg);
            s2_hi_next = '0;
        end
        else
        begin
            s2_lo_next = ACC_W'(s1_prod_reg[0]) + ACC_W'(s1_prod_reg[1]);
            s2_hi_next = ACC_W'(s1_prod_reg[2]) + ACC_W'(s1_prod_reg[3]);
        end
    end

    // Stage 3: full sum, with half an LSB added for round half up on a product or a scale.
    always_comb
    begin
        s3_valid_next = s2_valid_reg;
        s3_round_next = s2_round_reg;
        s3_acc_next   = s2_lo_reg + s2_hi_reg + (s2_round_reg ? HALF : '0);
    end

    // Stage 4: drop the fraction bits of a product or a scale and clip to the element range.
    always_comb
    begin
        s4_valid_next = s3_valid_reg;
        shifted       = s3_round_reg ? (s3_acc_reg >>> FRAC_BITS) : s3_acc_reg;
        upper         = shifted[ACC_W-1:ELEM_WIDTH-1];
        fits          = (&upper) | ~(|upper);
        if (fits)
        begin
            s4_value_next = shifted[ELEM_WIDTH-1:0];
        end
        else
        begin
            s4_value_next = shifted[ACC_W-1] ? ELEM_MIN : ELEM_MAX;
        end
        s4_clip_next = !fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= s1_op_next;
        s1_prod_reg  <= s1_prod_next;
        s1_sum_reg   <= s1_sum_next;
        s2_round_reg <= s2_round_next;
        s2_lo_reg    <= s2_lo_next;
        s2_hi_reg    <= s2_hi_next;
        s3_round_reg <= s3_round_next;
        s3_acc_reg   <= s3_acc_next;
        s4_value_reg <= s4_value_next;
        s4_clip_reg  <= s4_clip_next;
    end

    assign res.valid = s4_valid_reg;
    assign res.value = s4_value_reg;
    assign res.clip  = s4_clip_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        op_in.valid |-> ##4 res.valid)
        else $error("lane result missing four cycles after issue");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> $past(op_in.valid, 4))
        else $error("lane result without a matching issue");

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.clip) |-> ((res.value == ELEM_MAX) || (res.value == ELEM_MIN)))
        else $error("clipped element is not a range limit");

endmodule

`default_nettype wire

// File: hw/rtl/mxae_merge.sv
// Merging stage: joins the four lane elements into a result row and queues rows for output.
// Depends on mxae_pkg for the lane result and result word types.
`timescale 1ns / 1ps
`default_nettype none

module mxae_merge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mxae_pkg::lane_res_t  lane_res [mxae_pkg::DIM],
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output mxae_pkg::result_t         result
);
    import mxae_pkg::*;

    result_t            q_reg [DIM];
    logic [ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [ROW_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ROW_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    result_t            row_word;
    logic               push;
    logic               pop;

    assign push = lane_res[0].valid;
    assign pop  = result_valid && !result_stall;

    // Lane rows arrive in order, so a running count gives the row index.
    always_comb
    begin
        row_word.out_row       = row_cnt_reg;
        row_word.out_e0        = to_field(lane_res[0].value);
        row_word.out_e1        = to_field(lane_res[1].value);
        row_word.out_e2        = to_field(lane_res[2].value);
        row_word.out_e3        = to_field(lane_res[3].value);
        row_word.out_last      = (row_cnt_reg == ROW_W'(DIM - 1));
        row_word.out_saturated = lane_res[0].clip | lane_res[1].clip
                               | lane_res[2].clip | lane_res[3].clip;
    end

    always_comb
    begin
        row_cnt_next = push ? row_cnt_reg + 1'b1 : row_cnt_reg;
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= row_word;
        end
    end

    assign result_valid = (count_reg != '0);
    assign result       = q_reg[rd_ptr_reg];

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_res[0].valid == lane_res[1].valid) && (lane_res[0].valid == lane_res[2].valid)
        && (lane_res[0].valid == lane_res[3].valid))
        else $error("lane results out of step");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((count_reg < CNT_W'(DIM)) || pop))
        else $error("row pushed into a full output queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DIM))
        else $error("output queue count beyond depth");

endmodule

`default_nettype wire

// File: hw/rtl/matrix4x4_arith_engine_top.sv
// Top level of the 4x4 matrix arithmetic engine: row stores, issue sequencer, lanes, merge.
// Depends on mxae_pkg, mxae_lane and mxae_merge.
`timescale 1ns / 1ps
`default_nettype none

// Load rows of the left and right matrices one word per cycle when not stalled; the word
// marked final_row stores its row and starts the operation named by its command (add,
// subtract, scale by scale_factor, or matrix product), all in signed Q16.16 with each
// element saturated. After a final word the input stalls while one result row per cycle
// goes into four column lanes; each lane has a four-stage pipeline (multiply, pair sums,
// rounding add, shift and clip), and a four-row queue holds the results for output.
// Non-final words are taken one per cycle at any time outside the issuing of a result. A
// final word is held off until all four rows of the previous result have been taken. Rows
// never written since reset read back as undefined data.
module matrix4x4_arith_engine_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire mxae_pkg::item_t    item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output mxae_pkg::result_t       result
);
    import mxae_pkg::*;

    elem_t              left_reg  [DIM][DIM];
    elem_t              right_reg [DIM][DIM];
    elem_t              item_left  [DIM];
    elem_t              item_right [DIM];

    seq_state_t         state_reg, state_next;
    logic [ROW_W-1:0]   issue_row_reg, issue_row_next;
    cmd_t               cmd_reg, cmd_next;
    elem_t              scale_reg, scale_next;
    logic [CNT_W-1:0]   pending_reg, pending_next;

    logic               item_accept;
    logic               issuing;
    logic               result_pop;
    lane_op_t           lane_op  [DIM];
    lane_res_t          lane_res [DIM];

    always_comb
    begin
        item_left[0]  = to_elem(item.left_e0);
        item_left[1]  = to_elem(item.left_e1);
        item_left[2]  = to_elem(item.left_e2);
        item_left[3]  = to_elem(item.left_e3);
        item_right[0] = to_elem(item.right_e0);
        item_right[1] = to_elem(item.right_e1);
        item_right[2] = to_elem(item.right_e2);
        item_right[3] = to_elem(item.right_e3);
    end

    assign item_accept = item_valid && !item_stall;
    assign result_pop  = result_valid && !result_stall;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        issue_row_next = issue_row_reg;
        cmd_next       = cmd_reg;
        scale_next     = scale_reg;
        unique case (state_reg)
            SEQ_LOAD:
            begin
                issue_row_next = '0;
                if (item_accept && item.final_row)
                begin
                    state_next = SEQ_ISSUE;
                    cmd_next   = item.command;
                    scale_next = to_elem(item.scale_factor);
                end
            end
            SEQ_ISSUE:
            begin
                issue_row_next = issue_row_reg + 1'b1;
                if (issue_row_reg == ROW_W'(DIM - 1))
                begin
                    state_next = SEQ_LOAD;
                end
            end
        endcase
        pending_next = pending_reg + CNT_W'(issuing) - CNT_W'(result_pop);
    end

    // Output logic: handshake and lane operand selection.
    always_comb
    begin
        issuing = (state_reg == SEQ_ISSUE);
        // Rows may load while results drain; a new final word waits for an empty engine.
        item_stall = issuing || (item.final_row && (pending_reg != '0));
        for (int c = 0; c < DIM; c++)
        begin
            lane_op[c].valid = issuing;
            lane_op[c].op    = cmd_reg;
            lane_op[c].a     = '0;
            lane_op[c].b     = '0;
            case (cmd_reg) inside
                CMD_ADD, CMD_SUB:
                begin
                    lane_op[c].a[0] = left_reg[issue_row_reg][c];
                    lane_op[c].b[0] = right_reg[issue_row_reg][c];
                end
                CMD_SCALE:
                begin
                    lane_op[c].a[0] = left_reg[issue_row_reg][c];
                    lane_op[c].b[0] = scale_reg;
                end
                CMD_MUL:
                begin
                    for (int k = 0; k < DIM; k++)
                    begin
                        lane_op[c].a[k] = left_reg[issue_row_reg][k];
                        lane_op[c].b[k] = right_reg[k][c];
                    end
                end
                default:
                begin
                    lane_op[c].a = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_LOAD;
            issue_row_reg <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_row_reg <= issue_row_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        scale_reg <= scale_next;
        if (item_accept)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                left_reg[item.row_index][c]  <= item_left[c];
                right_reg[item.row_index][c] <= item_right[c];
            end
        end
    end

    for (genvar g = 0; g < DIM; g++)
    begin : g_lane
        mxae_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .op_in (lane_op[g]),
            .res   (lane_res[g])
        );
    end

    mxae_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .lane_res     (lane_res),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_final_starts_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.final_row) |=> (state_reg == SEQ_ISSUE))
        else $error("final word did not start issuing");

    a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_reg != '0))
        else $error("result shown with nothing outstanding");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(DIM))
        else $error("more rows outstanding than one result holds");

endmodule

`default_nettype wire
